### rtl/core/mm4_pkg.sv
// shared constants, types and state codes for the 4x4 fixed-point matrix multiplier
// no dependencies; used by every module of the block but mm4_ram, and by its checker
`timescale 1ns / 1ps

package mm4_pkg;

  // element width inside the block (16..32); ports stay 32 bits wide
  localparam int DATA_WIDTH = 32;
  localparam int ELEM_W     = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DIM        = 4;
  localparam int DEPTH      = DIM * DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int K_W        = $clog2(DIM);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = PROD_W + 2;

  localparam int TDATA_IN_W  = 32;
  localparam int OUT_FLD_W   = ELEM_W + ADDR_W;
  localparam int TDATA_OUT_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]  LAST_LOAD = CNT_W'(2 * DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
  localparam logic [K_W-1:0]    LAST_K    = K_W'(DIM - 1);

  // saturation bounds as seen on the 32-bit output
  localparam logic [ELEM_W-1:0] SAT_MAX32 = ELEM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic [ELEM_W-1:0] SAT_MIN32 = ~SAT_MAX32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_ISSUE
  } mm4_state_e;

  // one multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } mm4_issue_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic out_valid;
  } mm4_status_t;

endpackage

### rtl/core/mm4_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mm4_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mm4_ctrl.sv
// sequencer: load counter, ram write control and multiply-accumulate issue
// depends on mm4_pkg
`timescale 1ns / 1ps

module mm4_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       we_left_o,
  output logic                       we_right_o,
  output logic [mm4_pkg::ADDR_W-1:0] waddr_o,
  output logic [mm4_pkg::ADDR_W-1:0] raddr_left_o,
  output logic [mm4_pkg::ADDR_W-1:0] raddr_right_o,
  output mm4_pkg::mm4_issue_t        issue_o,
  input  mm4_pkg::mm4_status_t       status_i
);

  mm4_pkg::mm4_state_e state_q, state_d;
  logic [mm4_pkg::CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [mm4_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [mm4_pkg::K_W-1:0]    k_q, k_d;
  logic                       load_xfer;

  assign load_xfer = in_valid_i && (state_q == mm4_pkg::ST_LOAD);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mm4_pkg::ST_LOAD: begin
        if (load_xfer && load_cnt_q == mm4_pkg::LAST_LOAD) begin
          state_d = mm4_pkg::ST_WAIT;
        end
      end
      mm4_pkg::ST_WAIT: begin
        if (!status_i.busy && !status_i.out_valid) begin
          state_d = mm4_pkg::ST_ISSUE;
        end
      end
      mm4_pkg::ST_ISSUE: begin
        if (k_q == mm4_pkg::LAST_K) begin
          state_d = (idx_q == mm4_pkg::LAST_IDX) ? mm4_pkg::ST_LOAD : mm4_pkg::ST_WAIT;
        end
      end
      default: state_d = mm4_pkg::ST_LOAD;
    endcase
  end

  // counters
  always_comb begin
    load_cnt_d = load_cnt_q;
    idx_d      = idx_q;
    k_d        = k_q;
    if (load_xfer) begin
      load_cnt_d = load_cnt_q + 1'b1;
    end
    if (state_q == mm4_pkg::ST_ISSUE) begin
      k_d = k_q + 1'b1;
      if (k_q == mm4_pkg::LAST_K) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    in_ready_o     = (state_q == mm4_pkg::ST_LOAD);
    we_left_o      = load_xfer && !load_cnt_q[mm4_pkg::CNT_W-1];
    we_right_o     = load_xfer && load_cnt_q[mm4_pkg::CNT_W-1];
    waddr_o        = load_cnt_q[mm4_pkg::ADDR_W-1:0];
    // left[k*4+row], right[col*4+k]
    raddr_left_o   = {k_q, idx_q[mm4_pkg::K_W-1:0]};
    raddr_right_o  = {idx_q[mm4_pkg::ADDR_W-1:mm4_pkg::K_W], k_q};
    issue_o.valid  = (state_q == mm4_pkg::ST_ISSUE);
    issue_o.first  = (k_q == '0);
    issue_o.last   = (k_q == mm4_pkg::LAST_K);
    issue_o.idx    = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mm4_pkg::ST_LOAD;
      load_cnt_q <= '0;
      idx_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      idx_q      <= idx_d;
      k_q        <= k_d;
    end
  end

endmodule

### rtl/core/mm4_mac.sv
// multiply-accumulate datapath: multiply, exact accumulate, shift, saturate, output register
// depends on mm4_pkg
`timescale 1ns / 1ps

module mm4_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mm4_pkg::mm4_issue_t            issue_i,
  input  logic [mm4_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [mm4_pkg::DATA_WIDTH-1:0] right_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [mm4_pkg::ELEM_W-1:0]     out_value_o,
  output logic [mm4_pkg::ADDR_W-1:0]     out_idx_o,
  output logic                           out_sat_o,
  output mm4_pkg::mm4_status_t           status_o
);

  localparam int DW     = mm4_pkg::DATA_WIDTH;
  localparam int ACC_W  = mm4_pkg::ACC_W;
  localparam int HI_LSB = DW - 1 + mm4_pkg::FRAC_BITS;

  // stage 1: ram data valid
  mm4_pkg::mm4_issue_t s1_q;
  // stage 2: product register
  mm4_pkg::mm4_issue_t s2_q;
  logic signed [mm4_pkg::PROD_W-1:0] prod_q;
  // stage 3: accumulator, fin_q marks a complete sum
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       fin_q;
  logic [mm4_pkg::ADDR_W-1:0] fin_idx_q;
  // stage 4: output register
  logic                       out_valid_q;
  logic [mm4_pkg::ELEM_W-1:0] out_value_q;
  logic [mm4_pkg::ADDR_W-1:0] out_idx_q;
  logic                       out_sat_q;

  logic [ACC_W-1:HI_LSB]   hi_bits;
  logic                    in_range;
  logic signed [DW-1:0]    sat_val;

  assign acc_d = (s2_q.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  // bits above the kept range must all match the sign
  assign hi_bits  = acc_q[ACC_W-1:HI_LSB];
  assign in_range = (&hi_bits) || !(|hi_bits);
  always_comb begin
    if (in_range) begin
      sat_val = acc_q[HI_LSB:mm4_pkg::FRAC_BITS];
    end else begin
      sat_val = acc_q[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q  <= issue_i;
      s2_q  <= s1_q;
      fin_q <= s2_q.valid && s2_q.last;
      if (fin_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(left_i) * $signed(right_i);
    if (s2_q.valid) begin
      acc_q     <= acc_d;
      fin_idx_q <= s2_q.idx;
    end
    if (fin_q) begin
      out_value_q <= mm4_pkg::ELEM_W'(sat_val);
      out_idx_q   <= fin_idx_q;
      out_sat_q   <= !in_range;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_idx_o   = out_idx_q;
  assign out_sat_o   = out_sat_q;

  assign status_o.busy      = s1_q.valid || s2_q.valid || fin_q;
  assign status_o.out_valid = out_valid_q;

endmodule

### rtl/core/matrix_multiply_4x4_core.sv
// 4x4 signed q16.16 matrix multiplier, top level
// depends on mm4_pkg, mm4_ram, mm4_ctrl and mm4_mac
`timescale 1ns / 1ps

// The block takes 32 elements on the slave stream, the left matrix and then the
// right one, both column-major (index column*4+row), and after the 32nd transfer
// sends the 16 product elements column-major on the master stream, tlast on the
// last one and tuser set where an element was clamped. Each element is the exact
// sum of four 32x32 products, shifted right by 16 (floor) and saturated. Loads run
// at one transfer per cycle. Each product element is then formed by reading its
// four operand pairs from the two 16-entry rams through the single multiplier;
// the sum passes the read, multiply and accumulate registers into the output
// register, and the next element starts only once these and the output register
// are empty, so every stall of the receiver holds the next element back. The
// multiplier and the one read port per ram set the throughput of a run. Input
// is not taken while the product is being formed, except that the next run's loads
// begin as soon as the last operand pair has been read. The left and right rams are
// not cleared at reset.

module matrix_multiply_4x4_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mm4_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,   // [31:0] element_value
  // master stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mm4_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,   // [31:0] product_value,
                                                            // [35:32] product_index,
                                                            // [39:36] zero
  output logic                            m_axis_tlast_o,   // last_of_run
  output logic                            m_axis_tuser_o    // [0] saturated
);

  localparam int DW = mm4_pkg::DATA_WIDTH;

  logic                       we_left, we_right;
  logic [mm4_pkg::ADDR_W-1:0] waddr, raddr_left, raddr_right;
  logic [DW-1:0]              wdata, left_rd, right_rd;
  mm4_pkg::mm4_issue_t        issue;
  mm4_pkg::mm4_status_t       status;
  logic [mm4_pkg::ELEM_W-1:0] out_value;
  logic [mm4_pkg::ADDR_W-1:0] out_idx;
  logic                       out_sat;

  // only the low DATA_WIDTH bits of an element are kept
  assign wdata = s_axis_tdata_i[DW-1:0];

  // load counter, ram writes and the read sequence
  mm4_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .we_left_o     (we_left),
    .we_right_o    (we_right),
    .waddr_o       (waddr),
    .raddr_left_o  (raddr_left),
    .raddr_right_o (raddr_right),
    .issue_o       (issue),
    .status_i      (status)
  );

  // left matrix store
  mm4_ram #(
    .Width (DW),
    .Depth (mm4_pkg::DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_left),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_left),
    .rdata_o (left_rd)
  );

  // right matrix store
  mm4_ram #(
    .Width (DW),
    .Depth (mm4_pkg::DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we_right),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_right),
    .rdata_o (right_rd)
  );

  // multiply, accumulate, saturate and hold the result for the master stream
  mm4_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .left_i      (left_rd),
    .right_i     (right_rd),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (out_value),
    .out_idx_o   (out_idx),
    .out_sat_o   (out_sat),
    .status_o    (status)
  );

  // pack result fields, zero fill to whole bytes
  assign m_axis_tdata_o = mm4_pkg::TDATA_OUT_W'({out_idx, out_value});
  assign m_axis_tlast_o = (out_idx == mm4_pkg::LAST_IDX);
  assign m_axis_tuser_o = out_sat;

endmodule

### rtl/core/mm4_checker.sv
// port-level checks for the 4x4 matrix multiplier, bound to the top level
// depends on mm4_pkg and matrix_multiply_4x4_core
`timescale 1ns / 1ps

module mm4_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_i,
  input logic                            m_axis_tvalid_i,
  input logic                            m_axis_tready_i,
  input logic [mm4_pkg::TDATA_OUT_W-1:0] m_axis_tdata_i,
  input logic                            m_axis_tlast_i,
  input logic                            m_axis_tuser_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // tlast marks the final index of the run
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tlast_i == (m_axis_tdata_i[35:32] == mm4_pkg::LAST_IDX)))
    else $error("tlast does not match product index");

  // a clamped element sits on a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |->
      (m_axis_tdata_i[31:0] == mm4_pkg::SAT_MAX32) ||
      (m_axis_tdata_i[31:0] == mm4_pkg::SAT_MIN32))
    else $error("saturated element not at a bound");

  // no loading while a product element other than the last is pending
  a_no_load_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tlast_i |-> !s_axis_tready_i)
    else $error("input accepted during product output");

endmodule

bind matrix_multiply_4x4_core mm4_checker u_mm4_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

### bench/testbench.sv
// self-checking bench for matrix_multiply_4x4_core: streams 4x4 q16.16 operand pairs
// and checks every product transfer against a local predictor of the multiplier
// depends on mm4_pkg and matrix_multiply_4x4_core
`timescale 1ns / 1ps

module testbench;
  import mm4_pkg::*;

  localparam int CLK_PERIOD_NS    = 8;
  localparam int RESET_CYCLES     = 10;
  localparam int RUN_LEN          = 2 * DEPTH;
  localparam int RANDOM_RUNS      = 2;
  localparam int QUIET_RUNS       = 1;
  localparam int HOLD_AT_RESULTS  = 40;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 60;
  localparam int MAX_REPORTS      = 10;
  localparam longint LIMIT_CYCLES = 200_000;

  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_TWO  = 32'h0002_0000;
  localparam logic [31:0] E_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] E_MIN  = 32'h8000_0000;
  localparam logic [31:0] E_LSB  = 32'h0000_0001;
  localparam logic [31:0] E_MLSB = 32'hFFFF_FFFF;

  typedef enum int {
    STYLE_SMALL,
    STYLE_WIDE,
    STYLE_MIXED,
    STYLE_SPARSE
  } run_style_e;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [ADDR_W-1:0] index;
    logic              sat;
    logic              last;
  } product_t;

  // one directed run: uniform fills, left optionally only on its diagonal
  typedef struct packed {
    logic [31:0] left_fill;
    logic        left_diag;
    logic [31:0] right_fill;
    logic        typed;
    logic [31:0] want_value;
    logic        want_sat;
  } fill_run_t;

  localparam fill_run_t DIRECTED_RUNS [8] = '{
    '{Q_ZERO, 1'b0, Q_ZERO,         1'b1, Q_ZERO,    1'b0},  // all zero
    '{E_MAX,  1'b0, E_MAX,          1'b1, SAT_MAX32, 1'b1},  // clamps high
    '{E_MIN,  1'b0, E_MAX,          1'b1, SAT_MIN32, 1'b1},  // clamps low
    '{E_MIN,  1'b0, E_MIN,          1'b1, SAT_MAX32, 1'b1},  // min times min clamps high
    '{E_MLSB, 1'b0, E_LSB,          1'b1, E_MLSB,    1'b0},  // -4 lsb floors to -1
    '{Q_ONE,  1'b1, E_MIN,          1'b1, E_MIN,     1'b0},  // identity keeps min exactly
    '{Q_TWO,  1'b1, 32'h4000_0000,  1'b1, SAT_MAX32, 1'b1},  // one past max
    '{32'h0000_FFFF, 1'b0, 32'h0001_8001, 1'b0, Q_ZERO, 1'b0} // low-half carries
  };

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;   // [31:0] product_value, [35:32] product_index
  logic                   m_axis_tlast_o;   // last_of_run
  logic                   m_axis_tuser_o;   // [0] saturated

  // predictor state: operands held sign-extended, wide enough for exact sums
  logic signed [69:0] left_elems  [DEPTH];
  logic signed [69:0] right_elems [DEPTH];
  int unsigned        loads_seen   = 0;
  product_t           product_q[$];
  product_t           oldest_product;
  int unsigned        results_seen = 0;
  int unsigned        errors       = 0;
  int unsigned        src_gap_odds = 0;
  int unsigned        sink_gap_odds = 0;

  matrix_multiply_4x4_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  // only the low DATA_WIDTH bits count, sign-extended
  function automatic logic signed [69:0] widen_element(logic [31:0] raw);
    logic [69:0] w;
    w = 70'(raw) & ((70'd1 << DATA_WIDTH) - 70'd1);
    if (w[DATA_WIDTH-1]) begin
      w = w - (70'd1 << DATA_WIDTH);
    end
    return signed'(w);
  endfunction

  function automatic logic [31:0] random_element(run_style_e style);
    case (style)
      STYLE_SMALL: begin
        return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;  // about +-16.0
      end
      STYLE_WIDE: begin
        return $urandom;
      end
      STYLE_MIXED: begin
        case ($urandom_range(0, 6))
          0:       return Q_ZERO;
          1:       return E_MAX;
          2:       return E_MIN;
          3:       return Q_ONE;
          4:       return 32'hFFFF_0000;
          5:       return $urandom;
          default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        endcase
      end
      default: begin
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000
                                           : Q_ZERO;
      end
    endcase
  endfunction

  // stores one operand; the 32nd of a run queues the 16 product elements
  task automatic load_element(input logic [31:0] raw, input logic typed,
                              input logic [31:0] want_value, input logic want_sat);
    logic signed [69:0] acc;
    logic signed [69:0] maxv;
    logic signed [69:0] minv;
    product_t           p;
    if (loads_seen < DEPTH) begin
      left_elems[loads_seen] = widen_element(raw);
    end else begin
      right_elems[loads_seen - DEPTH] = widen_element(raw);
    end
    loads_seen++;
    if (loads_seen == RUN_LEN) begin
      loads_seen = 0;
      maxv = (70'sd1 <<< (DATA_WIDTH - 1)) - 70'sd1;
      minv = -maxv - 70'sd1;
      for (int idx = 0; idx < DEPTH; idx++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          acc += left_elems[k * DIM + idx % DIM] * right_elems[(idx / DIM) * DIM + k];
        end
        acc = acc >>> FRAC_BITS;  // floor
        p.sat = 1'b0;
        if (acc > maxv) begin
          acc   = maxv;
          p.sat = 1'b1;
        end else if (acc < minv) begin
          acc   = minv;
          p.sat = 1'b1;
        end
        p.value = acc[ELEM_W-1:0];
        p.index = ADDR_W'(idx);
        p.last  = (idx == DEPTH - 1);
        if (typed) begin
          p.value = want_value;
          p.sat   = want_sat;
        end
        product_q.push_back(p);
      end
    end
  endtask

  // one transfer on the slave stream, with an optional idle burst ahead of it
  task automatic put_element(input logic [31:0] raw, input logic typed,
                             input logic [31:0] want_value, input logic want_sat);
    @(negedge clk_i);
    if (src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    load_element(raw, typed, want_value, want_sat);
  endtask

  task automatic feed_run(input logic [31:0] elems [RUN_LEN], input logic typed,
                          input logic [31:0] want_value, input logic want_sat);
    for (int i = 0; i < RUN_LEN; i++) begin
      put_element(elems[i], typed, want_value, want_sat);
    end
  endtask

  task automatic pick_idling(input bit quiet);
    src_gap_odds  = quiet ? 0 : 4 * $urandom_range(0, 3);
    sink_gap_odds = quiet ? 0 : 4 * $urandom_range(0, 3);
  endtask

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // product checker, compares each accepted transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (product_q.size() == 0) begin
        flag_error("product with none pending", 64'd0, 64'(m_axis_tdata_o));
      end else begin
        oldest_product = product_q.pop_front();
        if (m_axis_tdata_o[ELEM_W-1:0] !== oldest_product.value) begin
          flag_error($sformatf("product_value at index %0d", oldest_product.index),
                     64'(oldest_product.value), 64'(m_axis_tdata_o[ELEM_W-1:0]));
        end
        if (m_axis_tdata_o[ELEM_W +: ADDR_W] !== oldest_product.index) begin
          flag_error("product_index", 64'(oldest_product.index),
                     64'(m_axis_tdata_o[ELEM_W +: ADDR_W]));
        end
        if (m_axis_tuser_o !== oldest_product.sat) begin
          flag_error($sformatf("saturated at index %0d", oldest_product.index),
                     64'(oldest_product.sat), 64'(m_axis_tuser_o));
        end
        if (m_axis_tlast_o !== oldest_product.last) begin
          flag_error($sformatf("last_of_run at index %0d", oldest_product.index),
                     64'(oldest_product.last), 64'(m_axis_tlast_o));
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off that backs up the block
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AT_RESULTS) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (sink_gap_odds != 0 && $urandom_range(0, sink_gap_odds) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] elems [RUN_LEN];
    fill_run_t   row;
    run_style_e  style;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed runs: zeros, extremes, floor rounding, clamping both ways
    foreach (DIRECTED_RUNS[r]) begin
      row = DIRECTED_RUNS[r];
      pick_idling(1'b0);
      for (int i = 0; i < RUN_LEN; i++) begin
        if (i >= DEPTH) begin
          elems[i] = row.right_fill;
        end else if (row.left_diag && (i % (DIM + 1)) != 0) begin
          elems[i] = Q_ZERO;
        end else begin
          elems[i] = row.left_fill;
        end
      end
      feed_run(elems, row.typed, row.want_value, row.want_sat);
    end

    // random runs, idling switched off for the last one
    for (int r = 0; r < RANDOM_RUNS; r++) begin
      pick_idling(r >= RANDOM_RUNS - QUIET_RUNS);
      style = run_style_e'($urandom_range(0, 3));
      for (int i = 0; i < RUN_LEN; i++) begin
        elems[i] = random_element(style);
      end
      feed_run(elems, 1'b0, Q_ZERO, 1'b0);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (product_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
